[rtl/core/fpfa_pkg.sv]
package fpfa_pkg;

   // Field widths of the request and response transactions
   localparam int OPCODE_W   = 2;
   localparam int PINDEX_W   = 5;
   localparam int PSIZE_W    = 16;
   localparam int REQSIZE_W  = 16;
   localparam int STATUS_W   = 2;
   localparam int FRAGMENT_W = 16;
   localparam int REQNUM_W   = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 6;
   localparam int POLICY_W    = 2;
   localparam int COUNT_W     = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_POLICY      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTITION_COUNT = 4'd1;

   // Defaults for the top-level parameters
   localparam int DEFAULT_PARTITIONS = 32;
   localparam int DEFAULT_SIZE_BITS  = 16;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ACK     = 2'd2;

   // Fit policies; the unused code behaves as first fit
   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   // Control strobes into the partition table
   typedef struct packed {
      logic load_en;
      logic clear_all;
      logic mark_en;
      logic rd_en;
   } table_ctl_type;

   // Outcome of one allocation scan
   typedef struct packed {
      logic                  found;
      logic [FRAGMENT_W-1:0] fragment;
   } scan_result_type;

endpackage

[rtl/core/fpfa_ifaces.sv]
interface fpfa_req_if;
   import fpfa_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [PINDEX_W-1:0]  partition_index;
   logic [PSIZE_W-1:0]   partition_size;
   logic [REQSIZE_W-1:0] request_size;

   modport source (
      output valid, opcode, partition_index, partition_size, request_size,
      input  ready
   );
   modport sink (
      input  valid, opcode, partition_index, partition_size, request_size,
      output ready
   );
endinterface

interface fpfa_rsp_if;
   import fpfa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [PINDEX_W-1:0]   granted_index;
   logic [FRAGMENT_W-1:0] fragment;
   logic [REQNUM_W-1:0]   request_number;

   modport source (
      output valid, status, granted_index, fragment, request_number,
      input  ready
   );
   modport sink (
      input  valid, status, granted_index, fragment, request_number,
      output ready
   );
endinterface

[rtl/core/fpfa_table.sv]
module fpfa_table #(
   parameter int PARTITIONS = fpfa_pkg::DEFAULT_PARTITIONS,
   parameter int SIZE_BITS  = fpfa_pkg::DEFAULT_SIZE_BITS,
   localparam int IDX_W     = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fpfa_pkg::table_ctl_type ctl,
   input  logic [IDX_W-1:0]        wr_addr,
   input  logic [SIZE_BITS-1:0]    wr_size,
   input  logic [IDX_W-1:0]        mark_addr,
   input  logic [IDX_W-1:0]        rd_addr,
   output logic [SIZE_BITS-1:0]    rd_size,
   output logic                    rd_busy
);
   import fpfa_pkg::*;

   logic [SIZE_BITS-1:0]  size_mem [PARTITIONS];
   logic [PARTITIONS-1:0] busy_ff;
   logic [PARTITIONS-1:0] busy_in;
   logic [SIZE_BITS-1:0]  rd_size_ff;
   logic                  rd_busy_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_en) begin
         size_mem[wr_addr] <= wr_size;
      end
      if (ctl.rd_en) begin
         rd_size_ff <= size_mem[rd_addr];
         rd_busy_ff <= busy_ff[rd_addr];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (ctl.clear_all) begin
         busy_in = '0;
      end else begin
         if (ctl.load_en) begin
            busy_in[wr_addr] = 1'b0;
         end
         if (ctl.mark_en) begin
            busy_in[mark_addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign rd_size = rd_size_ff;
   assign rd_busy = rd_busy_ff;

endmodule

[rtl/core/fpfa_scan.sv]
module fpfa_scan #(
   parameter int PARTITIONS = fpfa_pkg::DEFAULT_PARTITIONS,
   parameter int SIZE_BITS  = fpfa_pkg::DEFAULT_SIZE_BITS,
   localparam int IDX_W     = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1,
   localparam int CNT_W     = $clog2(PARTITIONS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fpfa_pkg::REQSIZE_W-1:0]    request_size,
   input  logic [fpfa_pkg::POLICY_W-1:0]     policy,
   input  logic [CNT_W-1:0]                  active_count,
   output logic                              rd_en,
   output logic [IDX_W-1:0]                  rd_addr,
   input  logic [SIZE_BITS-1:0]              rd_size,
   input  logic                              rd_busy,
   output logic                              mark_en,
   output logic [IDX_W-1:0]                  mark_addr,
   output logic                              busy,
   output logic                              done,
   input  logic                              take,
   output fpfa_pkg::scan_result_type         result,
   output logic [IDX_W-1:0]                  pick
);
   import fpfa_pkg::*;

   localparam int CMP_W = (SIZE_BITS > REQSIZE_W) ? SIZE_BITS : REQSIZE_W;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_WRITE = 4'b0100,
      S_DONE  = 4'b1000
   } scan_state_type;

   scan_state_type        state_ff, state_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [CMP_W-1:0]      best_ff, best_in;
   logic [REQSIZE_W-1:0]  req_ff;
   logic [FRAGMENT_W-1:0] frag_ff, frag_in;
   logic [CMP_W-1:0]      size_ext, req_ext;
   logic                  fits, better;

   assign size_ext = CMP_W'(rd_size);
   assign req_ext  = CMP_W'(req_ff);
   assign fits     = !rd_busy && (size_ext >= req_ext);
   // First fit keeps the first hit; best and worst fit replace on a strict win only
   assign better   = !found_ff
                     || ((policy == POLICY_BEST)  && (size_ext < best_ff))
                     || ((policy == POLICY_WORST) && (size_ext > best_ff));

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      count_in     = count_ff;
      cmp_valid_in = 1'b0;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      frag_in      = frag_ff;
      rd_en        = 1'b0;
      mark_en      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
               issue_in = '0;
               count_in = active_count;
               found_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (issue_ff < count_ff) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               issue_in     = issue_ff + CNT_W'(1);
            end else if (!cmp_valid_ff) begin
               state_in = S_WRITE;
            end
            if (cmp_valid_ff && fits && better) begin
               found_in = 1'b1;
               pick_in  = cmp_idx_ff;
               best_in  = size_ext;
            end
         end
         S_WRITE: begin
            mark_en  = found_ff;
            frag_in  = found_ff ? FRAGMENT_W'(best_ff - req_ext) : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         issue_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         issue_ff     <= issue_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_addr;
      pick_ff    <= pick_in;
      best_ff    <= best_in;
      frag_ff    <= frag_in;
      if (start && (state_ff == S_IDLE)) begin
         req_ff <= request_size;
      end
   end

   assign rd_addr         = issue_ff[IDX_W-1:0];
   assign mark_addr       = pick_ff;
   assign busy            = (state_ff != S_IDLE);
   assign done            = (state_ff == S_DONE);
   assign result.found    = found_ff;
   assign result.fragment = frag_ff;
   assign pick            = pick_ff;

endmodule

[rtl/core/fixed_partition_fit_allocator_unit.sv]
// Channel   Port         Dir  Payload
// request   req_channel  in   opcode, partition_index, partition_size, request_size
// response  rsp_channel  out  status, granted_index, fragment, request_number
// config    csr_*        in   csr_index, csr_write_data (write only)
//
// Load, clear and unknown opcodes present their response in the cycle after acceptance.
// An allocate scans the active partitions through the table's single read
// port, one entry a cycle, then marks the winner and loads the outcome into
// the response register once that register is free.
// Synchronous reset frees every partition and zeroes the request counter and configuration registers.
// A response held by rsp_channel.ready blocks the next request; nothing is dropped.
module fixed_partition_fit_allocator_unit #(
   parameter int PARTITIONS = fpfa_pkg::DEFAULT_PARTITIONS,
   parameter int SIZE_BITS  = fpfa_pkg::DEFAULT_SIZE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   fpfa_req_if.sink                         req_channel,
   fpfa_rsp_if.source                       rsp_channel,
   input  logic                             csr_write_enable,
   input  logic [fpfa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import fpfa_pkg::*;

   localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int CNT_W = $clog2(PARTITIONS + 1);

   logic [POLICY_W-1:0]   policy_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [REQNUM_W-1:0]   reqnum_ff, reqnum_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [PINDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [FRAGMENT_W-1:0] rsp_frag_ff, rsp_frag_in;
   logic [REQNUM_W-1:0]   rsp_num_ff, rsp_num_in;

   logic                  accept, slot_free, load_hit, rsp_load;
   logic                  scan_start, scan_busy, scan_done, scan_take;
   logic                  scan_rd_en, scan_mark_en;
   logic [IDX_W-1:0]      scan_rd_addr, scan_mark_addr, scan_pick;
   logic [CNT_W-1:0]      active_count;
   scan_result_type       scan_result;
   table_ctl_type         tbl_ctl;
   logic [SIZE_BITS-1:0]  tbl_rd_size;
   logic                  tbl_rd_busy;

   assign slot_free         = !rsp_valid_ff || rsp_channel.ready;
   assign req_channel.ready = !scan_busy && slot_free;
   assign accept            = req_channel.valid && req_channel.ready;

   assign load_hit   = accept && (req_channel.opcode == OP_LOAD)
                       && (32'(req_channel.partition_index) < 32'(PARTITIONS));
   assign scan_start = accept && (req_channel.opcode == OP_ALLOC);
   assign scan_take  = scan_done && slot_free;

   assign active_count = (32'(count_ff) > 32'(PARTITIONS)) ? CNT_W'(PARTITIONS)
                                                            : CNT_W'(count_ff);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIRST;
         count_ff  <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_FIT_POLICY) begin
            policy_ff <= csr_write_data[POLICY_W-1:0];
         end else if (csr_index == CSR_PARTITION_COUNT) begin
            count_ff <= csr_write_data[COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      reqnum_in = reqnum_ff;
      if (accept && (req_channel.opcode == OP_CLEAR)) begin
         reqnum_in = '0;
      end else if (scan_start) begin
         reqnum_in = reqnum_ff + REQNUM_W'(1);
      end
   end

   always_comb begin
      tbl_ctl.load_en   = load_hit;
      tbl_ctl.clear_all = accept && (req_channel.opcode == OP_CLEAR);
      tbl_ctl.mark_en   = scan_mark_en;
      tbl_ctl.rd_en     = scan_rd_en;
   end

   // Response register: direct ack for non-allocate transactions, scan outcome otherwise
   always_comb begin
      rsp_load      = 1'b0;
      rsp_status_in = ST_ACK;
      rsp_index_in  = '0;
      rsp_frag_in   = '0;
      rsp_num_in    = '0;
      if (scan_take) begin
         rsp_load      = 1'b1;
         rsp_status_in = scan_result.found ? ST_GRANTED : ST_NONE;
         rsp_index_in  = scan_result.found ? PINDEX_W'(scan_pick) : '0;
         rsp_frag_in   = scan_result.fragment;
         rsp_num_in    = reqnum_ff;
      end else if (accept && !scan_start) begin
         rsp_load = 1'b1;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         reqnum_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         reqnum_ff    <= reqnum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_frag_ff   <= rsp_frag_in;
         rsp_num_ff    <= rsp_num_in;
      end
   end

   assign rsp_channel.valid          = rsp_valid_ff;
   assign rsp_channel.status         = rsp_status_ff;
   assign rsp_channel.granted_index  = rsp_index_ff;
   assign rsp_channel.fragment       = rsp_frag_ff;
   assign rsp_channel.request_number = rsp_num_ff;

   fpfa_table #(
      .PARTITIONS (PARTITIONS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tbl_ctl),
      .wr_addr   (IDX_W'(req_channel.partition_index)),
      .wr_size   (SIZE_BITS'(req_channel.partition_size)),
      .mark_addr (scan_mark_addr),
      .rd_addr   (scan_rd_addr),
      .rd_size   (tbl_rd_size),
      .rd_busy   (tbl_rd_busy)
   );

   fpfa_scan #(
      .PARTITIONS (PARTITIONS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .request_size (req_channel.request_size),
      .policy       (policy_ff),
      .active_count (active_count),
      .rd_en        (scan_rd_en),
      .rd_addr      (scan_rd_addr),
      .rd_size      (tbl_rd_size),
      .rd_busy      (tbl_rd_busy),
      .mark_en      (scan_mark_en),
      .mark_addr    (scan_mark_addr),
      .busy         (scan_busy),
      .done         (scan_done),
      .take         (scan_take),
      .result       (scan_result),
      .pick         (scan_pick)
   );

endmodule

[test/fpfa_alloc_checker.sv]
module fpfa_alloc_checker (
   input  logic                             clock,
   input  logic                             reset,
   fpfa_req_if                              req_mon,
   fpfa_rsp_if                              rsp_mon,
   input  logic                             csr_write_enable,
   input  logic [fpfa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               fail_count,
   output int                               outstanding
);
   import fpfa_pkg::*;

   localparam int TABLE_DEPTH = DEFAULT_PARTITIONS;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [PINDEX_W-1:0]   granted_index;
      logic [FRAGMENT_W-1:0] fragment;
      logic [REQNUM_W-1:0]   request_number;
   } alloc_reply_type;

   logic [PSIZE_W-1:0]  part_size [TABLE_DEPTH];
   bit                  part_busy [TABLE_DEPTH];
   logic [REQNUM_W-1:0] alloc_serial;
   logic [POLICY_W-1:0] policy_sel;
   logic [COUNT_W-1:0]  live_count;
   alloc_reply_type     awaited_replies [$];
   int                  miss_total = 0;
   int                  reply_seen = 0;

   task automatic flag_mismatch(input string msg);
      $display("[%0t] %s", $realtime, msg);
      miss_total++;
   endtask

   // Apply one transaction to the shadow table and return the reply it earns.
   function automatic alloc_reply_type predict_reply(
      input logic [OPCODE_W-1:0]  op,
      input logic [PINDEX_W-1:0]  pidx,
      input logic [PSIZE_W-1:0]   psize,
      input logic [REQSIZE_W-1:0] want
   );
      alloc_reply_type r;
      int scan_len;
      int pick;
      int j;
      r = '0;
      r.status = ST_ACK;
      case (op)
         OP_LOAD: begin
            part_size[pidx] = psize;
            part_busy[pidx] = 1'b0;
         end
         OP_CLEAR: begin
            foreach (part_busy[k]) part_busy[k] = 1'b0;
            alloc_serial = '0;
         end
         OP_ALLOC: begin
            alloc_serial = alloc_serial + REQNUM_W'(1);
            // counts beyond the table saturate
            scan_len = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count);
            pick = -1;
            for (j = 0; j < scan_len; j++) begin
               if (!part_busy[j] && part_size[j] >= want) begin
                  if (pick < 0)
                     pick = j;
                  else if (policy_sel == POLICY_BEST && part_size[j] < part_size[pick])
                     pick = j;
                  else if (policy_sel == POLICY_WORST && part_size[j] > part_size[pick])
                     pick = j;
               end
            end
            r.request_number = alloc_serial;
            if (pick >= 0) begin
               part_busy[pick] = 1'b1;
               r.status        = ST_GRANTED;
               r.granted_index = pick[PINDEX_W-1:0];
               r.fragment      = part_size[pick] - want;
            end else begin
               r.status = ST_NONE;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_reply_type got;
      alloc_reply_type due;
      if (reset) begin
         foreach (part_size[k]) begin
            part_size[k] = '0;
            part_busy[k] = 1'b0;
         end
         alloc_serial = '0;
         policy_sel   = POLICY_FIRST;
         live_count   = '0;
         awaited_replies.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_FIT_POLICY)
               policy_sel = csr_write_data[POLICY_W-1:0];
            else if (csr_index == CSR_PARTITION_COUNT)
               live_count = csr_write_data[COUNT_W-1:0];
         end
         if (req_mon.valid && req_mon.ready)
            awaited_replies.push_back(predict_reply(req_mon.opcode, req_mon.partition_index,
                                                    req_mon.partition_size,
                                                    req_mon.request_size));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status         = rsp_mon.status;
            got.granted_index  = rsp_mon.granted_index;
            got.fragment       = rsp_mon.fragment;
            got.request_number = rsp_mon.request_number;
            reply_seen++;
            if (awaited_replies.size() == 0) begin
               flag_mismatch($sformatf("reply %0d arrived with no transaction pending",
                                       reply_seen));
            end else begin
               due = awaited_replies.pop_front();
               if (got.status !== due.status)
                  flag_mismatch($sformatf("reply %0d: status %0d, expected %0d",
                                          reply_seen, got.status, due.status));
               if (got.granted_index !== due.granted_index)
                  flag_mismatch($sformatf("reply %0d: granted_index %0d, expected %0d",
                                          reply_seen, got.granted_index, due.granted_index));
               if (got.fragment !== due.fragment)
                  flag_mismatch($sformatf("reply %0d: fragment %0d, expected %0d",
                                          reply_seen, got.fragment, due.fragment));
               if (got.request_number !== due.request_number)
                  flag_mismatch($sformatf("reply %0d: request_number %0d, expected %0d",
                                          reply_seen, got.request_number,
                                          due.request_number));
            end
         end
      end
      fail_count  <= miss_total;
      outstanding <= awaited_replies.size();
   end

endmodule

[test/tb_fixed_partition_fit_allocator_unit.sv]
module tb_fixed_partition_fit_allocator_unit;
   import fpfa_pkg::*;

   localparam int PART_TOTAL    = DEFAULT_PARTITIONS;
   localparam int SIZE_TOP      = (1 << PSIZE_W) - 1;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 64;

   localparam logic [OPCODE_W-1:0]   OP_SPARE       = 2'd3;
   localparam logic [POLICY_W-1:0]   POLICY_SPARE   = 2'd3;
   localparam logic [CSR_DATA_W-1:0] COUNT_OVERSIZE = 6'd63;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     fail_count;
   int                     outstanding;
   int                     quiet_cycles = 0;
   int                     stall_left = 0;
   bit                     calm = 1'b0;
   int                     part_shadow [PART_TOTAL];

   fpfa_req_if req_bus();
   fpfa_rsp_if rsp_bus();

   fixed_partition_fit_allocator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   fpfa_alloc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   always #1 clock = ~clock;

   // Mostly short idle spans, now and then a long one.
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return $urandom_range(1, 3);
      else if (roll < 96)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Favor a handful of repeated sizes so best and worst fit see ties.
   function automatic logic [PSIZE_W-1:0] pick_part_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return PSIZE_W'($urandom);
         default: return PSIZE_W'($urandom_range(1, 8) * 64);
      endcase
   endfunction

   always @(posedge clock) begin
      if (calm) begin
         stall_left    <= 0;
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
         stall_left    <= idle_span() - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(
      input logic [OPCODE_W-1:0]  op,
      input logic [PINDEX_W-1:0]  pidx,
      input logic [PSIZE_W-1:0]   psize,
      input logic [REQSIZE_W-1:0] want
   );
      int gap;
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_span();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.opcode          <= op;
      req_bus.partition_index <= pidx;
      req_bus.partition_size  <= psize;
      req_bus.request_size    <= want;
      if (op == OP_LOAD)
         part_shadow[pidx] = int'(psize);
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   // Hold the sender until every transaction has been answered.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic program_regs(
      input logic [CSR_DATA_W-1:0] pol,
      input logic [CSR_DATA_W-1:0] cnt,
      input bit                    junk
   );
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FIT_POLICY;
      csr_write_data   <= pol;
      @(posedge clock);
      csr_index        <= CSR_PARTITION_COUNT;
      csr_write_data   <= cnt;
      @(posedge clock);
      if (junk) begin
         // writes past the last register must be ignored
         csr_index      <= CSR_INDEX_W'($urandom_range(2, (1 << CSR_INDEX_W) - 1));
         csr_write_data <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_item();
      int roll;
      int near;
      logic [PINDEX_W-1:0]  pidx;
      logic [PSIZE_W-1:0]   psize;
      logic [REQSIZE_W-1:0] want;
      roll  = $urandom_range(0, 99);
      pidx  = PINDEX_W'($urandom);
      psize = PSIZE_W'($urandom);
      want  = REQSIZE_W'($urandom);
      if (roll < 55) begin
         case ($urandom_range(0, 9))
            0: want = '0;
            1: want = '1;
            2: ;
            default: begin
               // aim at a loaded size so the fit decision is close
               near = part_shadow[$urandom_range(0, PART_TOTAL - 1)]
                      + int'($urandom_range(0, 4)) - 2;
               if (near < 0)
                  near = 0;
               if (near > SIZE_TOP)
                  near = SIZE_TOP;
               want = near[REQSIZE_W-1:0];
            end
         endcase
         send_item(OP_ALLOC, pidx, psize, want);
      end else if (roll < 85) begin
         send_item(OP_LOAD, pidx, pick_part_size(), want);
      end else if (roll < 95) begin
         send_item(OP_CLEAR, pidx, psize, want);
      end else begin
         send_item(OP_SPARE, pidx, psize, want);
      end
   endtask

   initial begin
      int i;
      int phase;
      logic [CSR_DATA_W-1:0] pol_data;
      logic [CSR_DATA_W-1:0] cnt_data;

      reset                   <= 1'b1;
      csr_write_enable        <= 1'b0;
      csr_index               <= '0;
      csr_write_data          <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.opcode          <= '0;
      req_bus.partition_index <= '0;
      req_bus.partition_size  <= '0;
      req_bus.request_size    <= '0;
      foreach (part_shadow[k]) part_shadow[k] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no partitions in use yet, then an undefined opcode with every bit set
      send_item(OP_ALLOC, '0, '0, 16'd5);
      send_item(OP_SPARE, '1, '1, '1);

      drain();
      program_regs(CSR_DATA_W'(POLICY_FIRST), 6'd4, 1'b0);
      send_item(OP_LOAD, 5'd0, '1, '0);
      send_item(OP_LOAD, 5'd1, 16'd100, '0);
      send_item(OP_LOAD, 5'd2, 16'd50, '0);
      send_item(OP_LOAD, 5'd3, 16'd100, '0);
      send_item(OP_LOAD, 5'd31, '0, '0);
      send_item(OP_ALLOC, '0, '0, '0);
      send_item(OP_ALLOC, '0, '0, 16'd60);
      send_item(OP_ALLOC, '0, '0, '1);
      send_item(OP_CLEAR, '0, '0, '0);

      drain();
      program_regs(CSR_DATA_W'(POLICY_BEST), 6'd4, 1'b0);
      send_item(OP_ALLOC, '0, '0, 16'd60);
      send_item(OP_ALLOC, '0, '0, '0);
      send_item(OP_ALLOC, '0, '0, 16'd100);
      send_item(OP_LOAD, 5'd1, 16'd100, '0);

      drain();
      program_regs(CSR_DATA_W'(POLICY_WORST), 6'd4, 1'b0);
      send_item(OP_ALLOC, '0, '0, 16'd1);
      send_item(OP_ALLOC, '0, '0, 16'd1);
      send_item(OP_ALLOC, '0, '0, 16'd1);
      send_item(OP_CLEAR, '1, '1, '1);

      drain();
      program_regs(CSR_DATA_W'(POLICY_SPARE), 6'd4, 1'b1);
      send_item(OP_ALLOC, '0, '0, 16'd50);
      send_item(OP_ALLOC, '0, '0, 16'd100);
      send_item(OP_SPARE, '0, '0, '0);

      // define every table entry before any scan can read it
      drain();
      program_regs(CSR_DATA_W'(POLICY_FIRST), CSR_DATA_W'(PART_TOTAL), 1'b1);
      for (i = 0; i < PART_TOTAL; i++)
         send_item(OP_LOAD, PINDEX_W'(i), pick_part_size(), REQSIZE_W'($urandom));

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         case (phase)
            0:       pol_data = CSR_DATA_W'(POLICY_FIRST);
            1:       pol_data = CSR_DATA_W'(POLICY_BEST);
            2:       pol_data = CSR_DATA_W'(POLICY_WORST);
            3:       pol_data = CSR_DATA_W'(POLICY_SPARE);
            default: pol_data = CSR_DATA_W'($urandom);
         endcase
         case (phase)
            0, 5:    cnt_data = CSR_DATA_W'(PART_TOTAL);
            1:       cnt_data = COUNT_OVERSIZE;
            2:       cnt_data = 6'd1;
            3:       cnt_data = CSR_DATA_W'(PART_TOTAL + 1);
            4:       cnt_data = '0;
            default: cnt_data = CSR_DATA_W'($urandom);
         endcase
         program_regs(pol_data, cnt_data, $urandom_range(0, 2) == 0);
         calm <= (phase % 3 == 2);
         repeat (PHASE_ITEMS) send_random_item();
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
